>>> rtl/bpf_pkg.sv
package bpf_pkg;

  // sizes of the pixel and of the arithmetic
  localparam int unsigned NUM_BANDS   = 4;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned SUM_W       = SAMPLE_BITS + $clog2(NUM_BANDS);
  localparam int unsigned DIV_W       = SUM_W - 1;
  localparam int unsigned PROD_W      = 2 * SAMPLE_BITS;
  localparam int unsigned MAG_W       = PROD_W - 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SAMPLE_BITS;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam logic [CNT_W-1:0] BAND_COUNT_RST = CNT_W'(NUM_BANDS);
  localparam sample_t          NODATA_RST     = SAMPLE_BITS'(-9999);

  // saturation limits on the quotient magnitude
  localparam logic [MAG_W-1:0] SAT_POS = MAG_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] SAT_NEG = MAG_W'(64'd1 << (SAMPLE_BITS - 1));
  localparam sample_t          SMAX    = SAMPLE_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam sample_t          SMIN    = SAMPLE_BITS'(64'd1 << (SAMPLE_BITS - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_COUNT = 2'd0,
    CFG_NODATA     = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    sample_t ms_band0;
    sample_t ms_band1;
    sample_t ms_band2;
    sample_t ms_band3;
    sample_t pan_sample;
    logic    end_of_frame;
  } pix_in_t;

  typedef struct packed {
    sample_t              fused_band0;
    sample_t              fused_band1;
    sample_t              fused_band2;
    sample_t              fused_band3;
    logic [NUM_BANDS-1:0] saturated_mask;
    logic                 end_of_frame_out;
  } pix_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] band_count;
    sample_t          nodata;
  } cfg_t;

  // one classified pixel waiting for division
  typedef struct packed {
    logic [NUM_BANDS-1:0]             ok;
    logic [NUM_BANDS-1:0][PROD_W-1:0] prod;
    logic [SUM_W-1:0]                 sum;
    logic                             eof;
  } q_ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/bpf_front.sv
module bpf_front import bpf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  input  pix_in_t pix_i,
  input  cfg_t    cfg_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output q_ent_t  ent_o
);

  sample_t                        band [NUM_BANDS];
  logic [CNT_W:0]                 active_cnt;
  logic [NUM_BANDS-1:0]           use_b;
  logic signed [SUM_W-1:0]        sum_c;
  logic signed [PROD_W-1:0]       prod_c [NUM_BANDS];
  logic                           pan_ok;
  logic                           adv;
  logic                           accept;
  q_ent_t                         ent_d;
  q_ent_t                         ent_q;
  logic                           ent_v_d;
  logic                           ent_v_q;

  assign band[0] = pix_i.ms_band0;
  assign band[1] = pix_i.ms_band1;
  assign band[2] = pix_i.ms_band2;
  assign band[3] = pix_i.ms_band3;

  assign pan_ok = (pix_i.pan_sample != cfg_i.nodata);

  // band counts above the lane count clamp to all lanes
  always_comb begin
    if ({1'b0, cfg_i.band_count} > (CNT_W + 1)'(NUM_BANDS)) begin
      active_cnt = (CNT_W + 1)'(NUM_BANDS);
    end else begin
      active_cnt = {1'b0, cfg_i.band_count};
    end
  end

  always_comb begin
    sum_c = '0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      use_b[b]  = ((CNT_W + 1)'(b) < active_cnt) && (band[b] != cfg_i.nodata);
      prod_c[b] = band[b] * pix_i.pan_sample;
      if (use_b[b]) begin
        sum_c = sum_c + SUM_W'(band[b]);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      ent_d.ok[b]   = use_b[b] && pan_ok;
      ent_d.prod[b] = prod_c[b];
    end
    ent_d.sum = sum_c;
    ent_d.eof = pix_i.end_of_frame;
  end

  // the stage holds only while its beat cannot enter the queue
  assign push_o = ent_v_q && !q_stat_i.full;
  assign adv    = !ent_v_q || !q_stat_i.full;
  assign busy_o = !adv;
  assign accept = start_i && adv;

  always_comb begin
    if (accept) begin
      ent_v_d = 1'b1;
    end else if (push_o) begin
      ent_v_d = 1'b0;
    end else begin
      ent_v_d = ent_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else begin
      ent_v_q <= ent_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

>>> rtl/bpf_queue.sv
module bpf_queue import bpf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_ent_t  ent_i,
  input  logic    pop_i,
  output q_ent_t  ent_o,
  output q_stat_t stat_o
);

  q_ent_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_d, wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_d, rd_ptr_q;
  logic [QPTR_W:0]   cnt_d, cnt_q;

  assign stat_o.full  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign ent_o        = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= ent_i;
    end
  end

endmodule

>>> rtl/bpf_back.sv
module bpf_back import bpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_stat_t  q_stat_i,
  input  q_ent_t   ent_i,
  input  sample_t  nodata_i,
  output logic     pop_o,
  output logic     done_o,
  output pix_out_t res_o
);

  // stage 0 is loaded from the queue, stage k has k quotient bits
  logic [MAG_W:0]       v_q;
  logic [NUM_BANDS-1:0] ok_q   [MAG_W+1];
  logic [NUM_BANDS-1:0] neg_q  [MAG_W+1];
  logic                 eof_q  [MAG_W+1];
  logic [DIV_W-1:0]     div_q  [MAG_W+1];
  logic [MAG_W-1:0]     num_q  [MAG_W+1][NUM_BANDS];
  logic [DIV_W-1:0]     rem_q  [MAG_W+1][NUM_BANDS];

  logic [MAG_W-1:0]     num_d  [MAG_W+1][NUM_BANDS];
  logic [DIV_W-1:0]     rem_d  [MAG_W+1][NUM_BANDS];
  logic [NUM_BANDS-1:0] ok_d;
  logic [NUM_BANDS-1:0] neg_d;

  logic signed [SUM_W-1:0]  sum_s;
  logic                     sum_pos;
  logic signed [PROD_W-1:0] prod_s [NUM_BANDS];
  logic signed [PROD_W-1:0] prod_abs [NUM_BANDS];

  sample_t              fused [NUM_BANDS];
  logic [NUM_BANDS-1:0] sat_c;
  pix_out_t             res_d;
  logic                 done_q;
  pix_out_t             res_q;

  // the divider pipeline never stalls, so it drains the queue freely
  assign pop_o = !q_stat_i.empty;

  assign sum_s   = $signed(ent_i.sum);
  assign sum_pos = !sum_s[SUM_W-1] && (sum_s != '0);

  // sign and magnitude of each product for the unsigned divider
  always_comb begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      prod_s[b]   = $signed(ent_i.prod[b]);
      neg_d[b]    = prod_s[b][PROD_W-1];
      prod_abs[b] = neg_d[b] ? -prod_s[b] : prod_s[b];
      ok_d[b]     = ent_i.ok[b] && sum_pos;
    end
  end

  // one restoring step per stage and lane
  always_comb begin
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;
    for (int b = 0; b < NUM_BANDS; b++) begin
      num_d[0][b] = prod_abs[b][MAG_W-1:0];
      rem_d[0][b] = '0;
    end
    for (int k = 1; k <= MAG_W; k++) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        trial       = {rem_q[k-1][b], num_q[k-1][b][MAG_W-1]};
        diff        = trial - {1'b0, div_q[k-1]};
        ge          = (trial >= {1'b0, div_q[k-1]});
        rem_d[k][b] = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        num_d[k][b] = {num_q[k-1][b][MAG_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[MAG_W-1:0], pop_o};
      done_q <= v_q[MAG_W];
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q[0]  <= ok_d;
    neg_q[0] <= neg_d;
    eof_q[0] <= ent_i.eof;
    div_q[0] <= sum_s[DIV_W-1:0];
    for (int b = 0; b < NUM_BANDS; b++) begin
      num_q[0][b] <= num_d[0][b];
      rem_q[0][b] <= rem_d[0][b];
    end
    for (int k = 1; k <= MAG_W; k++) begin
      ok_q[k]  <= ok_q[k-1];
      neg_q[k] <= neg_q[k-1];
      eof_q[k] <= eof_q[k-1];
      div_q[k] <= div_q[k-1];
      for (int b = 0; b < NUM_BANDS; b++) begin
        num_q[k][b] <= num_d[k][b];
        rem_q[k][b] <= rem_d[k][b];
      end
    end
    res_q <= res_d;
  end

  // sign restore and clipping to the sample range
  always_comb begin
    logic [MAG_W-1:0] quo;
    for (int b = 0; b < NUM_BANDS; b++) begin
      quo      = num_q[MAG_W][b];
      sat_c[b] = 1'b0;
      if (!ok_q[MAG_W][b]) begin
        fused[b] = nodata_i;
      end else if (neg_q[MAG_W][b]) begin
        if (quo > SAT_NEG) begin
          fused[b] = SMIN;
          sat_c[b] = 1'b1;
        end else begin
          fused[b] = SAMPLE_BITS'(0) - quo[SAMPLE_BITS-1:0];
        end
      end else begin
        if (quo > SAT_POS) begin
          fused[b] = SMAX;
          sat_c[b] = 1'b1;
        end else begin
          fused[b] = quo[SAMPLE_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    res_d.fused_band0      = fused[0];
    res_d.fused_band1      = fused[1];
    res_d.fused_band2      = fused[2];
    res_d.fused_band3      = fused[3];
    res_d.saturated_mask   = sat_c;
    res_d.end_of_frame_out = eof_q[MAG_W];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/brovey_pixel_fusion.sv
// brovey pan-sharpening of one pixel per beat
//
// pixel channel: pix_i is taken at a rising edge with start high and busy
// low. each pixel carries four multispectral samples, the pan sample and an
// end of frame marker.
// result channel: done_o is high for exactly one cycle with res_o holding
// the fused bands, the per-band saturation mask and the marker. results
// leave in pixel order and the receiver cannot hold them off.
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i selecting the
// band count (index 0) or the nodata value (index 1); other indexes are
// dropped. cfg_ready_o is always high; write only while no pixel is in flight.
// throughput: one pixel per cycle. the divider is a pipeline of one
// restoring step per stage, one lane per band, so it never holds a beat.
// path of a pixel: front register (loaded at the accepting edge), queue,
// divider load stage, 31 quotient-bit stages, output register.
// busy only rises if the front/back queue is full, which a free-running
// back never lets happen in steady state.
// reset: clears all valid bits and the queue, band count back to 4 and
// nodata back to -9999; no clearing pass is needed.
module brovey_pixel_fusion import bpf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel command
  input  logic                  start,
  output logic                  busy,
  input  pix_in_t               pix_i,
  // results
  output logic                  done_o,
  output pix_out_t              res_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // accept-to-strobe distance in edges, used by the checks below
  localparam int unsigned LAT = MAG_W + 4;

  logic [CNT_W-1:0] band_count_q, band_count_d;
  sample_t          nodata_q, nodata_d;
  cfg_t             cfg;

  q_stat_t          q_stat;
  logic             q_push;
  logic             q_pop;
  q_ent_t           front_ent;
  q_ent_t           back_ent;

  // configuration registers, writes never wait
  assign cfg_ready_o = 1'b1;

  always_comb begin
    band_count_d = band_count_q;
    nodata_d     = nodata_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BAND_COUNT: band_count_d = cfg_data_i[CNT_W-1:0];
        CFG_NODATA:     nodata_d     = cfg_data_i[SAMPLE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q <= BAND_COUNT_RST;
      nodata_q     <= NODATA_RST;
    end else begin
      band_count_q <= band_count_d;
      nodata_q     <= nodata_d;
    end
  end

  assign cfg.band_count = band_count_q;
  assign cfg.nodata     = nodata_q;

  // front: band selection, nodata tests, sum and the products
  bpf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .pix_i    (pix_i),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .ent_o    (front_ent)
  );

  // short queue parting the front from the divider
  bpf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .ent_i  (front_ent),
    .pop_i  (q_pop),
    .ent_o  (back_ent),
    .stat_o (q_stat)
  );

  // back: pipelined division, sign restore, clipping, output register
  bpf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .ent_i    (back_ent),
    .nodata_i (nodata_q),
    .pop_o    (q_pop),
    .done_o   (done_o),
    .res_o    (res_o)
  );

  // every accepted pixel comes out after the fixed pipeline depth
  a_accept_to_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o
  ) else $error("accepted pixel did not produce a result on time");

  // no result without a pixel accepted that many cycles earlier
  a_done_has_source: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT)
  ) else $error("result strobe without a matching accepted pixel");

  // end of frame marker follows its own pixel through the pipeline
  a_eof_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT (res_o.end_of_frame_out == $past(pix_i.end_of_frame, LAT))
  ) else $error("end of frame marker out of step with its pixel");

endmodule
